// ===== rtl/core/hcv_pkg.sv =====
// types, constants and helper functions shared by the hash chain log verifier
`default_nettype none

package hcv_pkg;

   localparam int COUNT_BITS = 24;
   localparam int LIMIT_BITS = 24;
   localparam int HEAD_BITS = 64;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 64;
   localparam int MID_DEPTH = 4;
   localparam int RSP_DEPTH = 4;
   localparam int LINK_LEN = 8;

   localparam logic [HEAD_BITS-1:0] GOLDEN = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [7:0] NEWLINE = 8'h0a;
   localparam logic [7:0] QUOTE = 8'h22;
   localparam logic [7:0] LINK_TEXT [LINK_LEN] = '{
      8'h22, 8'h70, 8'h72, 8'h65, 8'h76, 8'h22, 8'h3a, 8'h22
   };

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_EOF = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_MISSING = 2'd1;
   localparam logic [1:0] STATUS_MISMATCH = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_HEAD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_LIMIT = 2'd1;

   typedef enum logic [1:0] {
      OP_BYTE,
      OP_EOF,
      OP_RESTART
   } op_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] byte_value;
   } req_item_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] line_count;
      logic [HEAD_BITS-1:0]  chain_head;
      logic [1:0]            status;
      logic [COUNT_BITS-1:0] broken_line;
      logic                  final_res;
   } rsp_item_type;

   typedef struct packed {
      op_type              op;
      logic [7:0]          byte_value;
      logic                newline;
      logic                quote;
      logic [LINK_LEN-1:0] link_hit;
      logic                hex_ok;
      logic [3:0]          hex_digit;
   } cmd_type;

   typedef struct packed {
      logic mid_pop;
      logic out_push;
      logic summary_pend;
   } back_ctl_type;

   // multiply by 0x01000193 modulo 2^64 as shift-adds
   function automatic logic [HEAD_BITS-1:0] fnv_mul(input logic [HEAD_BITS-1:0] x);
      return x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hcv_fifo.sv =====
// small flip-flop queue with registered count, one push and one pop per cycle
`default_nettype none

module hcv_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full = (count_ff == CNT_BITS'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/hcv_front.sv =====
// front end: classifies each incoming item into a command for the checker
`default_nettype none

module hcv_front
   import hcv_pkg::*;
(
   input  wire logic         req_push,
   input  wire req_item_type req_item,
   input  wire logic         mid_full,
   output logic              cmd_push,
   output cmd_type           cmd
);

   logic       take;
   logic [7:0] b;

   assign take = req_push && !mid_full;
   assign b = req_item.byte_value;

   always_comb begin
      cmd = '0;
      cmd.op = OP_BYTE;
      cmd_push = 1'b0;
      case (req_item.kind)
         KIND_DATA: begin
            cmd.op = OP_BYTE;
            cmd_push = take;
         end
         KIND_EOF: begin
            cmd.op = OP_EOF;
            cmd_push = take;
         end
         KIND_RESTART: begin
            cmd.op = OP_RESTART;
            cmd_push = take;
         end
         default: begin
            cmd.op = OP_BYTE;
            cmd_push = 1'b0;
         end
      endcase

      cmd.hex_ok = 1'b1;
      cmd.hex_digit = 4'd0;
      if (b inside {[8'h30:8'h39]}) begin
         cmd.hex_digit = 4'(b - 8'h30);
      end else if (b inside {[8'h61:8'h66]}) begin
         cmd.hex_digit = 4'(b - 8'h57);
      end else if (b inside {[8'h41:8'h46]}) begin
         cmd.hex_digit = 4'(b - 8'h37);
      end else begin
         cmd.hex_ok = 1'b0;
      end

      for (int i = 0; i < LINK_LEN; i++) begin
         cmd.link_hit[i] = (b == LINK_TEXT[i]);
      end

      cmd.byte_value = b;
      cmd.newline = (b == NEWLINE);
      cmd.quote = (b == QUOTE);
   end

endmodule

`default_nettype wire

// ===== rtl/core/hcv_back.sv =====
// back end: link matcher, hex parser, line hash and chain state
`default_nettype none

module hcv_back
   import hcv_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data,
   input  wire logic                      mid_empty,
   input  wire cmd_type                   cmd,
   input  wire logic                      out_full,
   output back_ctl_type                   ctl,
   output rsp_item_type                   out_item
);

   localparam int CMP_BITS = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

   logic [HEAD_BITS-1:0]  start_head_ff;
   logic [LIMIT_BITS-1:0] line_limit_ff;

   logic [HEAD_BITS-1:0]  head_ff, head_in;
   logic [HEAD_BITS-1:0]  line_hash_ff, line_hash_in;
   logic [COUNT_BITS-1:0] lines_seen_ff, lines_seen_in;
   logic [3:0]            match_pos_ff, match_pos_in;
   logic [4:0]            hex_count_ff, hex_count_in;
   logic [HEAD_BITS-1:0]  hex_value_ff, hex_value_in;
   logic                  field_found_ff, field_found_in;
   logic                  hex_stopped_ff, hex_stopped_in;
   logic                  line_open_ff, line_open_in;
   logic                  stopped_ff, stopped_in;
   logic [COUNT_BITS-1:0] break_line_ff, break_line_in;
   logic [1:0]            broken_kind_ff, broken_kind_in;
   logic                  pend_ff, pend_in;

   always_comb begin
      logic       do_finish;
      logic       do_clear;
      logic [1:0] st;

      do_finish = 1'b0;
      do_clear = 1'b0;
      st = STATUS_OK;
      head_in = head_ff;
      line_hash_in = line_hash_ff;
      lines_seen_in = lines_seen_ff;
      match_pos_in = match_pos_ff;
      hex_count_in = hex_count_ff;
      hex_value_in = hex_value_ff;
      field_found_in = field_found_ff;
      hex_stopped_in = hex_stopped_ff;
      line_open_in = line_open_ff;
      stopped_in = stopped_ff;
      break_line_in = break_line_ff;
      broken_kind_in = broken_kind_ff;
      pend_in = pend_ff;
      ctl = '0;
      ctl.summary_pend = pend_ff;
      out_item = '{line_count: lines_seen_ff, chain_head: head_ff,
                   status: broken_kind_ff, broken_line: break_line_ff, final_res: 1'b1};

      if (pend_ff) begin
         if (!out_full) begin
            ctl.out_push = 1'b1;
            pend_in = 1'b0;
         end
      end else if (!mid_empty && !out_full) begin
         ctl.mid_pop = 1'b1;
         case (cmd.op)
            OP_BYTE: begin
               if (!stopped_ff) begin
                  line_open_in = 1'b1;
                  line_hash_in = fnv_mul(line_hash_ff ^ {56'd0, cmd.byte_value});
                  if (!field_found_ff) begin
                     if (!match_pos_ff[3] && cmd.link_hit[match_pos_ff[2:0]]) begin
                        match_pos_in = match_pos_ff + 1'b1;
                        if (match_pos_ff == 4'd7) begin
                           field_found_in = 1'b1;
                        end
                     end else begin
                        match_pos_in = cmd.quote ? 4'd1 : 4'd0;
                     end
                  end else if (!hex_stopped_ff) begin
                     if (!cmd.hex_ok) begin
                        hex_stopped_in = 1'b1;
                     end else begin
                        hex_value_in = {hex_value_ff[HEAD_BITS-5:0], cmd.hex_digit};
                        hex_count_in = hex_count_ff + 1'b1;
                        if (hex_count_ff == 5'd15) begin
                           hex_stopped_in = 1'b1;
                        end
                     end
                  end
                  do_finish = cmd.newline;
               end
            end
            OP_EOF: begin
               if (!stopped_ff && line_open_ff) begin
                  do_finish = 1'b1;
                  pend_in = 1'b1;
               end else begin
                  ctl.out_push = 1'b1;
               end
               stopped_in = 1'b1;
               do_clear = 1'b1;
            end
            OP_RESTART: begin
               head_in = start_head_ff;
               lines_seen_in = '0;
               stopped_in = 1'b0;
               break_line_in = '0;
               broken_kind_in = STATUS_OK;
               do_clear = 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (do_finish) begin
         if (lines_seen_ff != '1) begin
            lines_seen_in = lines_seen_ff + 1'b1;
         end
         if (!field_found_in) begin
            st = STATUS_MISSING;
         end else if (hex_value_in != head_ff) begin
            st = STATUS_MISMATCH;
         end
         if (st != STATUS_OK) begin
            break_line_in = lines_seen_in;
            broken_kind_in = st;
            stopped_in = 1'b1;
         end else begin
            head_in = line_hash_in;
         end
         if (line_limit_ff != '0 &&
             CMP_BITS'(lines_seen_in) >= CMP_BITS'(line_limit_ff)) begin
            stopped_in = 1'b1;
         end
         ctl.out_push = 1'b1;
         out_item = '{line_count: lines_seen_in, chain_head: head_in, status: st,
                      broken_line: break_line_in, final_res: 1'b0};
         do_clear = 1'b1;
      end

      if (do_clear) begin
         line_hash_in = head_in ^ GOLDEN;
         match_pos_in = '0;
         hex_count_in = '0;
         hex_value_in = '0;
         field_found_in = 1'b0;
         hex_stopped_in = 1'b0;
         line_open_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_head_ff <= '0;
         line_limit_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == CSR_START_HEAD) begin
            start_head_ff <= csr_data[HEAD_BITS-1:0];
         end else if (csr_index == CSR_LINE_LIMIT) begin
            line_limit_ff <= csr_data[LIMIT_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         line_hash_ff <= GOLDEN;
         lines_seen_ff <= '0;
         match_pos_ff <= '0;
         hex_count_ff <= '0;
         hex_value_ff <= '0;
         field_found_ff <= 1'b0;
         hex_stopped_ff <= 1'b0;
         line_open_ff <= 1'b0;
         stopped_ff <= 1'b0;
         break_line_ff <= '0;
         broken_kind_ff <= STATUS_OK;
         pend_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         line_hash_ff <= line_hash_in;
         lines_seen_ff <= lines_seen_in;
         match_pos_ff <= match_pos_in;
         hex_count_ff <= hex_count_in;
         hex_value_ff <= hex_value_in;
         field_found_ff <= field_found_in;
         hex_stopped_ff <= hex_stopped_in;
         line_open_ff <= line_open_in;
         stopped_ff <= stopped_in;
         break_line_ff <= break_line_in;
         broken_kind_ff <= broken_kind_in;
         pend_ff <= pend_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/hash_chain_log_verifier.sv =====
// top level of the hash chain log verifier
//
// Input queue (req_push / req_full, item req_item): one log byte, an end of
// file marker or a restart request per item. An item is taken at every edge
// with req_push high and req_full low, one item per cycle while not stalled.
// Result queue (rsp_empty / rsp_pop, item rsp_item): one item per finished
// line and one summary item with final_res set at end of file.
// Register port (csr_write, csr_index, csr_data): start head and line limit;
// write only while the block is idle.
// A result item passes through the command queue and the output queue
// before it is visible. End of file with an unterminated line yields that
// line's item and then the summary. The line hash update (xor and multiply
// by the prime as shift-adds) is combinational and registered once per byte.
// A command queue parts classification from checking and an output queue
// holds results; if rsp_pop stays low the output queue fills, the checker
// stalls, the command queue fills and req_full rises. No item is dropped.
// Reset clears both queues, the registers and the chain state (head zero).
`default_nettype none

module hash_chain_log_verifier
   import hcv_pkg::*;
#(
   parameter int MID_QUEUE_DEPTH = MID_DEPTH,
   parameter int RSP_QUEUE_DEPTH = RSP_DEPTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_push,
   input  wire req_item_type              req_item,
   output logic                           req_full,
   output logic                           rsp_empty,
   input  wire logic                      rsp_pop,
   output rsp_item_type                   rsp_item,
   input  wire logic                      csr_write,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic         cmd_push;
   cmd_type      cmd_in_q;
   cmd_type      cmd_out_q;
   logic         mid_full;
   logic         mid_empty;
   logic         out_full;
   back_ctl_type back_ctl;
   rsp_item_type back_item;

   assign req_full = mid_full;

   hcv_front u_front (
      .req_push (req_push),
      .req_item (req_item),
      .mid_full (mid_full),
      .cmd_push (cmd_push),
      .cmd      (cmd_in_q)
   );

   hcv_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (MID_QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_q),
      .full      (mid_full),
      .pop       (back_ctl.mid_pop),
      .pop_data  (cmd_out_q),
      .empty     (mid_empty)
   );

   hcv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .mid_empty (mid_empty),
      .cmd       (cmd_out_q),
      .out_full  (out_full),
      .ctl       (back_ctl),
      .out_item  (back_item)
   );

   hcv_fifo #(
      .WIDTH ($bits(rsp_item_type)),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_ctl.out_push),
      .push_data (back_item),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_item),
      .empty     (rsp_empty)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      back_ctl.out_push |-> !out_full)
      else $error("result pushed into a full output queue");

   a_pend_blocks_pop: assert property (@(posedge clock) disable iff (reset)
      back_ctl.summary_pend |-> !back_ctl.mid_pop)
      else $error("command taken while a summary is pending");

   a_pend_drains: assert property (@(posedge clock) disable iff (reset)
      back_ctl.summary_pend && !out_full |-> back_ctl.out_push)
      else $error("pending summary not emitted");

   a_pop_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      back_ctl.mid_pop |-> !mid_empty && !out_full)
      else $error("command popped without data or output room");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// self-checking testbench for the hash chain log verifier: predicted line results vs rtl
`timescale 1ns / 1ps

module tb
   import hcv_pkg::*;
();

   localparam logic [7:0] LF = 8'h0a;
   localparam logic [7:0] DQUOTE = 8'h22;
   localparam logic [63:0] SEED_MIX = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [63:0] FNV_PRIME32 = 64'h0000_0000_0100_0193;
   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;
   localparam string LINK_FIELD = "\"prev\":\"";
   localparam int ITEM_TARGET = 1900;
   localparam int SETTLE_CYCLES = 12;
   localparam int PRESS_CYCLES = 600;
   localparam int PRESS_PHASE = 2;

   typedef enum {GOOD_LINK, NO_LINK, BAD_LINK, SHORT_LINK, DOUBLE_LINK} line_shape_type;

   class chain_tracker;
      logic [63:0] start_head_reg;
      logic [COUNT_BITS-1:0] limit_reg;
      logic [63:0] head;
      logic [63:0] line_hash;
      logic [63:0] hex_value;
      logic [COUNT_BITS-1:0] lines_seen;
      logic [COUNT_BITS-1:0] break_line;
      logic [1:0] broken_kind;
      int unsigned match_pos;
      int unsigned hex_count;
      bit field_found;
      bit hex_stopped;
      bit line_open;
      bit stopped;
      rsp_item_type pending_line_reports[$];
      int unsigned mismatches;
      int unsigned busy_items;
      int unsigned lines_ok;
      int unsigned breaks;
      int unsigned summaries;

      function new();
         start_head_reg = '0;
         limit_reg = '0;
         restart();
      endfunction

      function void clear_line();
         line_hash = head ^ SEED_MIX;
         match_pos = 0;
         hex_count = 0;
         hex_value = '0;
         field_found = 0;
         hex_stopped = 0;
         line_open = 0;
      endfunction

      function void restart();
         head = start_head_reg;
         lines_seen = '0;
         stopped = 0;
         break_line = '0;
         broken_kind = STATUS_OK;
         clear_line();
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] idx,
                                   logic [CSR_DATA_BITS-1:0] data);
         if (idx == CSR_START_HEAD) begin
            start_head_reg = data;
         end else if (idx == CSR_LINE_LIMIT) begin
            limit_reg = data[COUNT_BITS-1:0];
         end
      endfunction

      function int nibble_of(logic [7:0] c);
         if (c >= "0" && c <= "9") return int'(c) - int'("0");
         if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
         if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
         return -1;
      endfunction

      function void hash_byte(logic [7:0] c);
         int d;
         line_open = 1;
         line_hash = (line_hash ^ {56'd0, c}) * FNV_PRIME32;
         if (!field_found) begin
            if (match_pos < 8 && c == LINK_FIELD[match_pos]) begin
               match_pos++;
               if (match_pos == 8) field_found = 1;
            end else begin
               match_pos = (c == DQUOTE) ? 1 : 0;
            end
         end else if (!hex_stopped) begin
            d = nibble_of(c);
            if (d < 0) begin
               hex_stopped = 1;
            end else begin
               hex_value = {hex_value[59:0], 4'(d)};
               hex_count++;
               if (hex_count >= 16) hex_stopped = 1;
            end
         end
      endfunction

      function void expect_report(logic [COUNT_BITS-1:0] cnt, logic [63:0] hd,
                                  logic [1:0] st, logic [COUNT_BITS-1:0] brk, logic fin);
         rsp_item_type r;
         r.line_count = cnt;
         r.chain_head = hd;
         r.status = st;
         r.broken_line = brk;
         r.final_res = fin;
         pending_line_reports.push_back(r);
      endfunction

      function void close_line();
         logic [1:0] st;
         st = STATUS_OK;
         if (lines_seen != {COUNT_BITS{1'b1}}) lines_seen++;
         if (!field_found) st = STATUS_MISSING;
         else if (hex_value != head) st = STATUS_MISMATCH;
         if (st != STATUS_OK) begin
            break_line = lines_seen;
            broken_kind = st;
            stopped = 1;
            breaks++;
         end else begin
            head = line_hash;
            lines_ok++;
         end
         if (!stopped && limit_reg != 0 && lines_seen >= limit_reg) stopped = 1;
         expect_report(lines_seen, head, st, break_line, 1'b0);
         clear_line();
      endfunction

      function void absorb_item(req_item_type it);
         case (it.kind)
            KIND_DATA: begin
               if (!stopped) begin
                  busy_items++;
                  hash_byte(it.byte_value);
                  if (it.byte_value == LF) close_line();
               end
            end
            KIND_EOF: begin
               busy_items++;
               if (!stopped && line_open) close_line();
               expect_report(lines_seen, head, broken_kind, break_line, 1'b1);
               summaries++;
               stopped = 1;
               clear_line();
            end
            KIND_RESTART: begin
               busy_items++;
               restart();
            end
            default: ;
         endcase
      endfunction

      task flag(string what);
         if (mismatches < 40) $display("MISMATCH at %0t: %s", $time, what);
         mismatches++;
      endtask

      task check_report(rsp_item_type got);
         rsp_item_type want;
         if (pending_line_reports.size() == 0) begin
            flag($sformatf("result with nothing expected: %p", got));
            return;
         end
         want = pending_line_reports.pop_front();
         if (got.line_count !== want.line_count)
            flag($sformatf("line_count %0d, want %0d", got.line_count, want.line_count));
         if (got.chain_head !== want.chain_head)
            flag($sformatf("chain_head %h, want %h", got.chain_head, want.chain_head));
         if (got.status !== want.status)
            flag($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.broken_line !== want.broken_line)
            flag($sformatf("broken_line %0d, want %0d", got.broken_line, want.broken_line));
         if (got.final_res !== want.final_res)
            flag($sformatf("final_res %0d, want %0d", got.final_res, want.final_res));
      endtask
   endclass

   logic clock;
   logic reset;
   logic req_push;
   req_item_type req_item;
   logic req_full;
   logic rsp_empty;
   logic rsp_pop;
   rsp_item_type rsp_item;
   logic csr_write;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   chain_tracker tracker = new();
   logic [7:0] line_bytes[$];
   bit hold_request;
   bit hold_seen;
   int unsigned full_cycles;
   int unsigned sender_calm;
   int unsigned phase_count;

   hash_chain_log_verifier u_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_item(req_item),
      .req_full(req_full),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_item(rsp_item),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) tracker.check_report(rsp_item);
   end

   // result side: random stalls, calm stretches and one long hold
   initial begin
      int stall;
      int calm;
      rsp_pop <= 1'b0;
      stall = 0;
      calm = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 0;
            hold_seen = 1;
            stall = PRESS_CYCLES;
         end
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            stall--;
         end else begin
            rsp_pop <= 1'b1;
            if (calm > 0) calm--;
            else if ($urandom_range(0, 3) == 0) stall = pick_gap();
            else if ($urandom_range(0, 99) == 0) calm = $urandom_range(50, 300);
         end
      end
   end

   task automatic send_item(input req_item_type it);
      int gap;
      if (sender_calm > 0) begin
         gap = 0;
         sender_calm--;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 199) == 0) sender_calm = $urandom_range(50, 250);
      end
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= it;
      do begin
         @(posedge clock);
         if (req_full) full_cycles++;
      end while (req_full);
      tracker.absorb_item(it);
   endtask

   task automatic send_op(input logic [1:0] kind);
      req_item_type it;
      it.kind = kind;
      it.byte_value = 8'($urandom);
      send_item(it);
   endtask

   task automatic send_data(input logic [7:0] b);
      req_item_type it;
      it.kind = KIND_DATA;
      it.byte_value = b;
      send_item(it);
   endtask

   task automatic flush_line();
      while (line_bytes.size() != 0) send_data(line_bytes.pop_front());
   endtask

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
   endfunction

   function automatic void add_filler(int n);
      logic [7:0] c;
      for (int i = 0; i < n; i++) begin
         do c = 8'($urandom); while (c == LF);
         line_bytes.push_back(c);
      end
   endfunction

   function automatic void add_hex(logic [63:0] v, int digits);
      logic [3:0] nib;
      for (int k = 0; k < digits; k++) begin
         nib = v[63-4*k -: 4];
         if (nib < 10) line_bytes.push_back(8'("0") + 8'(nib));
         else if ($urandom_range(0, 1) == 1) line_bytes.push_back(8'("A") + 8'(nib) - 8'd10);
         else line_bytes.push_back(8'("a") + 8'(nib) - 8'd10);
      end
   endfunction

   task automatic send_line(input line_shape_type shape, input bit terminate);
      case ($urandom_range(0, 4))
         1: add_filler($urandom_range(1, 6));
         2: begin
            add_text("{\"pre");
            add_filler($urandom_range(0, 3));
         end
         3: line_bytes.push_back(DQUOTE);
         default: ;
      endcase
      case (shape)
         GOOD_LINK: begin
            add_text(LINK_FIELD);
            add_hex(tracker.head, 16);
            if ($urandom_range(0, 4) == 0) add_text("7");
         end
         BAD_LINK: begin
            add_text(LINK_FIELD);
            add_hex(tracker.head ^ (64'd1 << $urandom_range(0, 63)), 16);
         end
         SHORT_LINK: begin
            add_text(LINK_FIELD);
            add_hex(tracker.head, $urandom_range(1, 15));
            add_text(",");
         end
         DOUBLE_LINK: begin
            add_text(LINK_FIELD);
            add_hex(tracker.head, 16);
            add_filler($urandom_range(0, 3));
            add_text(LINK_FIELD);
            add_hex({$urandom, $urandom}, 16);
         end
         default: begin
            add_text("\"prev\" ");
            add_filler($urandom_range(0, 8));
         end
      endcase
      add_text("\",\"msg\":\"");
      add_filler($urandom_range(0, 10));
      if (terminate) line_bytes.push_back(LF);
      flush_line();
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      tracker.write_register(idx, data);
   endtask

   task automatic settle();
      req_push <= 1'b0;
      while (tracker.pending_line_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure_phase(input int unsigned phase);
      logic [63:0] hd;
      logic [23:0] lim;
      int r;
      r = $urandom_range(0, 9);
      hd = (r == 0) ? 64'd0 : (r == 1) ? '1 : {$urandom, $urandom};
      r = $urandom_range(0, 9);
      lim = (r < 5) ? 24'd0 : (r < 8) ? 24'($urandom_range(1, 6)) :
            (r == 8) ? '1 : 24'($urandom);
      if (phase == 0) begin
         hd = '1;
         lim = '1;
      end else if (phase == 1) begin
         hd = '0;
         lim = 24'd1;
      end else if (phase == PRESS_PHASE) begin
         lim = '0;
      end
      write_csr(CSR_START_HEAD, hd);
      write_csr(CSR_LINE_LIMIT, {40'($urandom), lim});
      if ($urandom_range(0, 4) == 0) write_csr(CSR_SPARE_A, {$urandom, $urandom});
      if ($urandom_range(0, 4) == 0) write_csr(CSR_SPARE_B, {$urandom, $urandom});
      csr_write <= 1'b0;
   endtask

   initial begin
      int n_lines;
      int r;
      line_shape_type shape;
      req_push <= 1'b0;
      req_item <= '0;
      csr_write <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      reset <= 1'b1;
      hold_request = 0;
      hold_seen = 0;
      full_cycles = 0;
      sender_calm = 0;
      phase_count = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short directed run on reset settings: head zero, no limit
      send_op(KIND_SPARE);
      add_text(LINK_FIELD);
      line_bytes.push_back(LF);
      flush_line();
      send_data(LF);
      send_data(8'h00);
      send_data(8'hff);
      send_op(KIND_EOF);
      send_op(KIND_EOF);
      send_op(KIND_RESTART);
      add_text(LINK_FIELD);
      line_bytes.push_back(8'h00);
      flush_line();
      send_op(KIND_EOF);

      while (tracker.busy_items < ITEM_TARGET) begin
         settle();
         configure_phase(phase_count);
         send_op(KIND_RESTART);
         if (phase_count == PRESS_PHASE) hold_request = 1;
         n_lines = (phase_count == PRESS_PHASE) ? 16 : $urandom_range(1, 10);
         for (int i = 0; i < n_lines; i++) begin
            r = $urandom_range(0, 99);
            shape = (r < 78) ? GOOD_LINK : (r < 83) ? DOUBLE_LINK : (r < 88) ? BAD_LINK :
                    (r < 94) ? SHORT_LINK : NO_LINK;
            if (phase_count == PRESS_PHASE) shape = GOOD_LINK;
            send_line(shape, !(i == n_lines - 1 && $urandom_range(0, 3) == 0));
            if (tracker.stopped) begin
               add_filler($urandom_range(0, 4));
               if ($urandom_range(0, 1) == 1) line_bytes.push_back(LF);
               flush_line();
               break;
            end
         end
         r = $urandom_range(0, 9);
         if (r < 7) send_op(KIND_EOF);
         else if (r == 7) send_op(KIND_SPARE);
         phase_count++;
      end
      send_op(KIND_EOF);
      settle();

      $display("run: %0d items in %0d phases; %0d lines chained, %0d breaks, %0d summaries",
               tracker.busy_items, phase_count, tracker.lines_ok, tracker.breaks,
               tracker.summaries);
      $display("run: long result hold %0s, %0d cycles with input backed up",
               hold_seen ? "done" : "missed", full_cycles);
      if (tracker.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
